/* hw/rtl/wpmc_pkg.sv */
// Shared types, constants and frame rotation helpers of the waypoint motion controller.
`default_nettype none

package wpmc_pkg;

    localparam int COORD_W    = 24;
    localparam int HEAD_W     = 20;
    localparam int GAIN_W     = 21;
    localparam int LIMIT_W    = 19;
    localparam int TOL_W      = 17;
    localparam int SPEED_W    = 20;
    localparam int CMD_W      = 2;
    localparam int MOTION_W   = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 21;
    localparam int IN_DATA_W  = 72;
    localparam int OUT_DATA_W = 48;
    localparam int QUEUE_DEPTH = 2;

    localparam logic signed [HEAD_W-1:0] PI_Q           = 20'sd205887;
    localparam logic signed [HEAD_W-1:0] TWO_PI_Q       = 20'sd411775;
    localparam logic signed [HEAD_W-1:0] EDGE_ZERO      = 20'sd11436;
    localparam logic signed [HEAD_W-1:0] EDGE_NINETY_LO = 20'sd91508;
    localparam logic signed [HEAD_W-1:0] EDGE_NINETY_HI = 20'sd114380;
    localparam logic signed [HEAD_W-1:0] EDGE_HALF      = 20'sd194445;

    localparam logic signed [COORD_W-1:0] COORD_MAX = 24'sd8388607;
    localparam logic signed [COORD_W-1:0] COORD_MIN = -24'sd8388608;

    localparam logic [CMD_W-1:0] CMD_ODOM = 2'd0;
    localparam logic [CMD_W-1:0] CMD_GOAL = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TICK = 2'd2;

    localparam logic [MOTION_W-1:0] MOTION_LEFT     = 3'd1;
    localparam logic [MOTION_W-1:0] MOTION_RIGHT    = 3'd2;
    localparam logic [MOTION_W-1:0] MOTION_STRAIGHT = 3'd3;
    localparam logic [MOTION_W-1:0] MOTION_STOP     = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_TURN_GAIN     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STRAIGHT_GAIN = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LINEAR_LIMIT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ANGULAR_LIMIT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DIST_TOL      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_HEAD_TOL      = 3'd5;

    localparam logic [GAIN_W-1:0]  RST_TURN_GAIN     = 21'd65536;
    localparam logic [GAIN_W-1:0]  RST_STRAIGHT_GAIN = 21'd72090;
    localparam logic [LIMIT_W-1:0] RST_LINEAR_LIMIT  = 19'd13107;
    localparam logic [LIMIT_W-1:0] RST_ANGULAR_LIMIT = 19'd39322;
    localparam logic [TOL_W-1:0]   RST_DIST_TOL      = 17'd328;
    localparam logic [TOL_W-1:0]   RST_HEAD_TOL      = 17'd655;

    typedef enum logic [1:0] {
        KIND_ODOM,
        KIND_GOAL,
        KIND_TICK
    } t_kind;

    typedef enum logic [2:0] {
        BAND_AHEAD,
        BAND_LEFT,
        BAND_BACK,
        BAND_RIGHT,
        BAND_NONE
    } t_band;

    typedef enum logic [1:0] {
        MODE_NONE     = 2'd0,
        MODE_TURN     = 2'd1,
        MODE_STRAIGHT = 2'd2,
        MODE_STOP     = 2'd3
    } t_mode;

    typedef struct packed {
        t_kind                      kind;
        t_band                      band;
        logic signed [COORD_W-1:0]  pos_x;
        logic signed [COORD_W-1:0]  pos_y;
        logic signed [HEAD_W-1:0]   heading;
        logic                       settled;
        logic [MOTION_W-1:0]        motion;
    } t_item;

    typedef struct packed {
        logic                  valid;
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } t_cfg_wr;

    function automatic logic signed [COORD_W-1:0] neg_sat(logic signed [COORD_W-1:0] v);
        logic signed [COORD_W-1:0] r;
        r = (v == COORD_MIN) ? COORD_MAX : -v;
        return r;
    endfunction

    function automatic t_band band_of(logic signed [HEAD_W-1:0] h);
        t_band b;
        if (h > -EDGE_ZERO && h < EDGE_ZERO) begin
            b = BAND_AHEAD;
        end else if (h > EDGE_NINETY_LO && h < EDGE_NINETY_HI) begin
            b = BAND_LEFT;
        end else if (h > EDGE_HALF || h < -EDGE_HALF) begin
            b = BAND_BACK;
        end else if (h > -EDGE_NINETY_HI && h < -EDGE_NINETY_LO) begin
            b = BAND_RIGHT;
        end else begin
            b = BAND_NONE;
        end
        return b;
    endfunction

    function automatic logic signed [COORD_W-1:0] rot_x(t_band b,
                                                       logic signed [COORD_W-1:0] x,
                                                       logic signed [COORD_W-1:0] y);
        logic signed [COORD_W-1:0] r;
        case (b)
            BAND_AHEAD: r = x;
            BAND_LEFT:  r = y;
            BAND_BACK:  r = neg_sat(x);
            BAND_RIGHT: r = neg_sat(y);
            default:    r = x;
        endcase
        return r;
    endfunction

    function automatic logic signed [COORD_W-1:0] rot_y(t_band b,
                                                       logic signed [COORD_W-1:0] x,
                                                       logic signed [COORD_W-1:0] y);
        logic signed [COORD_W-1:0] r;
        case (b)
            BAND_AHEAD: r = y;
            BAND_LEFT:  r = neg_sat(x);
            BAND_BACK:  r = neg_sat(y);
            BAND_RIGHT: r = x;
            default:    r = y;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/wpmc_front.sv */
// Front end: decode request kind, wrap odometry heading and rotate odometry position.
`default_nettype none

module wpmc_front (
    input  wire logic                                i_valid,
    input  wire logic                                i_ready,
    input  wire logic [wpmc_pkg::CMD_W-1:0]          i_command,
    input  wire logic [wpmc_pkg::IN_DATA_W-1:0]      i_data,
    output wpmc_pkg::t_item                          o_item,
    output logic                                     o_push
);

    logic signed [wpmc_pkg::COORD_W-1:0] px;
    logic signed [wpmc_pkg::COORD_W-1:0] py;
    logic signed [wpmc_pkg::HEAD_W-1:0]  hd;
    logic signed [wpmc_pkg::HEAD_W-1:0]  hd_wrap;
    wpmc_pkg::t_band                     odom_band;

    assign px = i_data[23:0];
    assign py = i_data[47:24];
    assign hd = i_data[67:48];

    always_comb begin
        if (hd > wpmc_pkg::PI_Q) begin
            hd_wrap = hd - wpmc_pkg::TWO_PI_Q;
        end else if (hd < -wpmc_pkg::PI_Q) begin
            hd_wrap = hd + wpmc_pkg::TWO_PI_Q;
        end else begin
            hd_wrap = hd;
        end
    end

    assign odom_band = wpmc_pkg::band_of(hd_wrap);

    always_comb begin
        o_item.settled = i_data[68];
        o_item.motion  = i_data[71:69];
        o_item.band    = odom_band;
        o_item.pos_x   = px;
        o_item.pos_y   = py;
        o_item.heading = hd;
        o_item.kind    = wpmc_pkg::KIND_TICK;
        o_push         = i_valid && i_ready;
        case (i_command)
            wpmc_pkg::CMD_ODOM: begin
                o_item.kind    = wpmc_pkg::KIND_ODOM;
                o_item.heading = hd_wrap;
                o_item.pos_x   = wpmc_pkg::rot_x(odom_band, px, py);
                o_item.pos_y   = wpmc_pkg::rot_y(odom_band, px, py);
            end
            wpmc_pkg::CMD_GOAL: begin
                o_item.kind = wpmc_pkg::KIND_GOAL;
            end
            wpmc_pkg::CMD_TICK: begin
                o_item.kind = wpmc_pkg::KIND_TICK;
            end
            default: begin
                // drop unknown kind
                o_push = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

/* hw/rtl/wpmc_queue.sv */
// Small first-in first-out queue of decoded requests between front and back.
`default_nettype none

module wpmc_queue #(
    parameter int DEPTH = wpmc_pkg::QUEUE_DEPTH
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wpmc_pkg::t_item      i_item,
    input  wire logic            i_pop,
    output wpmc_pkg::t_item      o_item,
    output logic                 o_valid,
    output logic                 o_full
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    wpmc_pkg::t_item  r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             do_pop;

    assign o_valid = (r_count != '0);
    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_item  = r_mem[r_rd_ptr];
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/wpmc_back.sv */
// Back end: controller state, configuration registers, gain multiply and speed clamp.
`default_nettype none

module wpmc_back (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wpmc_pkg::t_cfg_wr                     i_cfg,
    input  wpmc_pkg::t_item                       i_item,
    input  wire logic                             i_item_valid,
    output logic                                  o_pop,
    input  wire logic                             i_m_tready,
    output logic                                  o_m_tvalid,
    output logic [wpmc_pkg::OUT_DATA_W-1:0]       o_m_tdata
);

    localparam int COORD_W = wpmc_pkg::COORD_W;
    localparam int HEAD_W  = wpmc_pkg::HEAD_W;
    localparam int HDIFF_W = HEAD_W + 1;
    localparam int ERR_W   = COORD_W + 1;
    localparam int PROD_W  = ERR_W + wpmc_pkg::GAIN_W;
    localparam int SHIFT   = 16;
    localparam int PSH_W   = PROD_W - SHIFT;
    localparam int LIMIT_W = wpmc_pkg::LIMIT_W;
    localparam int SPEED_W = wpmc_pkg::SPEED_W;

    localparam logic signed [HDIFF_W-1:0] PI_D     = HDIFF_W'(wpmc_pkg::PI_Q);
    localparam logic signed [HDIFF_W-1:0] TWO_PI_D = HDIFF_W'(wpmc_pkg::TWO_PI_Q);

    typedef struct packed {
        logic             valid;
        logic             reached;
        logic             is_lin;
        logic             sign;
        logic [ERR_W-1:0] mag;
    } t_p1;

    typedef struct packed {
        logic             valid;
        logic             reached;
        logic             is_lin;
        logic             sign;
        logic [PSH_W-1:0] prod;
    } t_p2;

    logic [wpmc_pkg::GAIN_W-1:0]  r_turn_gain, r_straight_gain;
    logic [LIMIT_W-1:0]           r_linear_limit, r_angular_limit;
    logic [wpmc_pkg::TOL_W-1:0]   r_dist_tol, r_head_tol;

    wpmc_pkg::t_mode              r_mode, n_mode;
    logic                         r_no_cmd, n_no_cmd;
    logic                         r_at_rest, n_at_rest;
    logic signed [COORD_W-1:0]    r_robot_x, n_robot_x;
    logic signed [COORD_W-1:0]    r_robot_y, n_robot_y;
    logic signed [HEAD_W-1:0]     r_robot_heading, n_robot_heading;
    logic signed [COORD_W-1:0]    r_target_x, n_target_x;
    logic signed [COORD_W-1:0]    r_target_y, n_target_y;
    logic signed [HEAD_W-1:0]     r_target_heading, n_target_heading;

    t_p1                          r_p1, n_p1;
    t_p2                          r_p2, n_p2;
    logic                         r_out_valid;
    logic signed [SPEED_W-1:0]    r_out_lin, n_out_lin;
    logic signed [SPEED_W-1:0]    r_out_ang, n_out_ang;
    logic                         r_out_reached;

    logic                         en;
    logic                         pop;
    wpmc_pkg::t_band              goal_band;
    logic signed [HEAD_W-1:0]     th_eff;
    logic signed [HDIFF_W-1:0]    hdiff_raw, hdiff;
    logic [HDIFF_W-1:0]           habs;
    logic                         head_out;
    logic signed [ERR_W-1:0]      sdiff;
    logic [ERR_W-1:0]             sabs;
    logic                         dist_out;
    logic [PROD_W-1:0]            prod_full;
    logic [LIMIT_W-1:0]           limit;
    logic [LIMIT_W-1:0]           clamped;
    logic signed [SPEED_W-1:0]    speed;

    assign en    = !r_out_valid || i_m_tready;
    assign pop   = en && i_item_valid;
    assign o_pop = pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_turn_gain     <= wpmc_pkg::RST_TURN_GAIN;
            r_straight_gain <= wpmc_pkg::RST_STRAIGHT_GAIN;
            r_linear_limit  <= wpmc_pkg::RST_LINEAR_LIMIT;
            r_angular_limit <= wpmc_pkg::RST_ANGULAR_LIMIT;
            r_dist_tol      <= wpmc_pkg::RST_DIST_TOL;
            r_head_tol      <= wpmc_pkg::RST_HEAD_TOL;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                wpmc_pkg::CFG_TURN_GAIN:     r_turn_gain     <= i_cfg.data;
                wpmc_pkg::CFG_STRAIGHT_GAIN: r_straight_gain <= i_cfg.data;
                wpmc_pkg::CFG_LINEAR_LIMIT:  r_linear_limit  <= i_cfg.data[LIMIT_W-1:0];
                wpmc_pkg::CFG_ANGULAR_LIMIT: r_angular_limit <= i_cfg.data[LIMIT_W-1:0];
                wpmc_pkg::CFG_DIST_TOL:      r_dist_tol <= i_cfg.data[wpmc_pkg::TOL_W-1:0];
                wpmc_pkg::CFG_HEAD_TOL:      r_head_tol <= i_cfg.data[wpmc_pkg::TOL_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign goal_band = wpmc_pkg::band_of(r_robot_heading);

    always_comb begin
        th_eff = r_target_heading;
        if (r_target_heading == wpmc_pkg::PI_Q && r_robot_heading < 0) begin
            th_eff = -wpmc_pkg::PI_Q;
        end else if (r_target_heading == -wpmc_pkg::PI_Q && r_robot_heading > 0) begin
            th_eff = wpmc_pkg::PI_Q;
        end
    end

    assign hdiff_raw = $signed({th_eff[HEAD_W-1], th_eff})
                     - $signed({r_robot_heading[HEAD_W-1], r_robot_heading});

    always_comb begin
        if (hdiff_raw > PI_D) begin
            hdiff = hdiff_raw - TWO_PI_D;
        end else if (hdiff_raw < -PI_D) begin
            hdiff = hdiff_raw + TWO_PI_D;
        end else begin
            hdiff = hdiff_raw;
        end
    end

    assign habs     = hdiff[HDIFF_W-1] ? -hdiff : hdiff;
    assign head_out = habs >= HDIFF_W'(r_head_tol);

    assign sdiff    = $signed({r_target_x[COORD_W-1], r_target_x})
                    - $signed({r_robot_x[COORD_W-1], r_robot_x});
    assign sabs     = sdiff[ERR_W-1] ? -sdiff : sdiff;
    assign dist_out = sabs >= ERR_W'(r_dist_tol);

    // next controller state
    always_comb begin
        n_mode           = r_mode;
        n_no_cmd         = r_no_cmd;
        n_at_rest        = r_at_rest;
        n_robot_x        = r_robot_x;
        n_robot_y        = r_robot_y;
        n_robot_heading  = r_robot_heading;
        n_target_x       = r_target_x;
        n_target_y       = r_target_y;
        n_target_heading = r_target_heading;
        if (pop) begin
            case (i_item.kind)
                wpmc_pkg::KIND_ODOM: begin
                    n_at_rest       = i_item.settled;
                    n_robot_heading = i_item.heading;
                    if (i_item.band != wpmc_pkg::BAND_NONE) begin
                        n_robot_x = i_item.pos_x;
                        n_robot_y = i_item.pos_y;
                    end
                end
                wpmc_pkg::KIND_GOAL: begin
                    n_no_cmd = 1'b0;
                    if (goal_band != wpmc_pkg::BAND_NONE) begin
                        n_target_x = wpmc_pkg::rot_x(goal_band, i_item.pos_x, i_item.pos_y);
                        n_target_y = wpmc_pkg::rot_y(goal_band, i_item.pos_x, i_item.pos_y);
                    end
                    case (i_item.motion)
                        wpmc_pkg::MOTION_LEFT, wpmc_pkg::MOTION_RIGHT: begin
                            n_mode           = wpmc_pkg::MODE_TURN;
                            n_target_heading = i_item.heading;
                        end
                        wpmc_pkg::MOTION_STRAIGHT: n_mode = wpmc_pkg::MODE_STRAIGHT;
                        wpmc_pkg::MOTION_STOP:     n_mode = wpmc_pkg::MODE_STOP;
                        default: begin
                        end
                    endcase
                end
                wpmc_pkg::KIND_TICK: begin
                    case (r_mode)
                        wpmc_pkg::MODE_TURN: begin
                            n_target_heading = th_eff;
                            if (!head_out && r_at_rest) begin
                                n_mode = wpmc_pkg::MODE_STOP;
                            end
                        end
                        wpmc_pkg::MODE_STRAIGHT: begin
                            if (!dist_out && r_at_rest) begin
                                n_mode = wpmc_pkg::MODE_STOP;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                default: begin
                end
            endcase
        end
    end

    // tick result into the first stage
    always_comb begin
        n_p1.valid   = pop && (i_item.kind == wpmc_pkg::KIND_TICK);
        n_p1.reached = r_no_cmd || (r_mode == wpmc_pkg::MODE_STOP);
        n_p1.is_lin  = 1'b0;
        n_p1.sign    = 1'b0;
        n_p1.mag     = '0;
        case (r_mode)
            wpmc_pkg::MODE_TURN: begin
                if (head_out) begin
                    n_p1.sign = hdiff[HDIFF_W-1];
                    n_p1.mag  = ERR_W'(habs);
                end
            end
            wpmc_pkg::MODE_STRAIGHT: begin
                n_p1.is_lin = 1'b1;
                if (dist_out) begin
                    n_p1.sign = sdiff[ERR_W-1];
                    n_p1.mag  = sabs;
                end
            end
            default: begin
            end
        endcase
    end

    assign prod_full = PROD_W'(r_p1.mag)
                     * PROD_W'(r_p1.is_lin ? r_straight_gain : r_turn_gain);

    always_comb begin
        n_p2.valid   = r_p1.valid;
        n_p2.reached = r_p1.reached;
        n_p2.is_lin  = r_p1.is_lin;
        n_p2.sign    = r_p1.sign;
        n_p2.prod    = prod_full[PROD_W-1:SHIFT];
    end

    assign limit   = r_p2.is_lin ? r_linear_limit : r_angular_limit;
    assign clamped = (r_p2.prod > PSH_W'(limit)) ? limit : r_p2.prod[LIMIT_W-1:0];
    assign speed   = r_p2.sign ? -$signed(SPEED_W'(clamped)) : $signed(SPEED_W'(clamped));
    assign n_out_lin = r_p2.is_lin ? speed : '0;
    assign n_out_ang = r_p2.is_lin ? '0 : speed;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode           <= wpmc_pkg::MODE_STOP;
            r_no_cmd         <= 1'b1;
            r_at_rest        <= 1'b0;
            r_robot_x        <= '0;
            r_robot_y        <= '0;
            r_robot_heading  <= '0;
            r_target_x       <= '0;
            r_target_y       <= '0;
            r_target_heading <= '0;
            r_p1.valid       <= 1'b0;
            r_p2.valid       <= 1'b0;
            r_out_valid      <= 1'b0;
        end else begin
            r_mode           <= n_mode;
            r_no_cmd         <= n_no_cmd;
            r_at_rest        <= n_at_rest;
            r_robot_x        <= n_robot_x;
            r_robot_y        <= n_robot_y;
            r_robot_heading  <= n_robot_heading;
            r_target_x       <= n_target_x;
            r_target_y       <= n_target_y;
            r_target_heading <= n_target_heading;
            if (en) begin
                r_p1          <= n_p1;
                r_p2          <= n_p2;
                r_out_valid   <= r_p2.valid;
                r_out_lin     <= n_out_lin;
                r_out_ang     <= n_out_ang;
                r_out_reached <= r_p2.reached;
            end
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {(wpmc_pkg::OUT_DATA_W - 2 * SPEED_W - 1)'(0),
                         r_out_reached, r_out_ang, r_out_lin};

endmodule

`default_nettype wire

/* hw/rtl/waypoint_p_motion_controller.sv */
// Waypoint proportional motion controller: top level joining front, queue and back.
// A tick request's result is registered in the queue, then in r_p1, r_p2 and the output register, before o_m_tvalid.
// Throughput: one request per cycle, set by the back-end state update, while i_m_tready does not stall it.
// Odometry and command requests give no result; unknown kinds are dropped at the front.
// Reset (synchronous, active low): configuration to defaults, mode stop, queue empty.
`default_nettype none

module waypoint_p_motion_controller #(
    parameter int QUEUE_DEPTH = wpmc_pkg::QUEUE_DEPTH
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_s_tvalid,
    output logic                                     o_s_tready,
    // pos_x[23:0], pos_y[47:24], heading[67:48], settled[68], motion[71:69]
    input  wire logic [wpmc_pkg::IN_DATA_W-1:0]      i_s_tdata,
    // command[1:0]
    input  wire logic [wpmc_pkg::CMD_W-1:0]          i_s_tuser,
    output logic                                     o_m_tvalid,
    input  wire logic                                i_m_tready,
    // linear_speed[19:0], angular_speed[39:20], reached[40], zero[47:41]
    output logic [wpmc_pkg::OUT_DATA_W-1:0]          o_m_tdata,
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [wpmc_pkg::CFG_IDX_W-1:0]      i_cfg_addr,
    input  wire logic [wpmc_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    wpmc_pkg::t_item   front_item;
    wpmc_pkg::t_item   head_item;
    wpmc_pkg::t_cfg_wr cfg_wr;
    logic              push;
    logic              pop;
    logic              head_valid;
    logic              q_full;

    assign o_s_tready   = !q_full;
    assign o_cfg_ready  = 1'b1;
    assign cfg_wr.valid = i_cfg_valid;
    assign cfg_wr.index = i_cfg_addr;
    assign cfg_wr.data  = i_cfg_data;

    wpmc_front u_front (
        .i_valid   (i_s_tvalid),
        .i_ready   (o_s_tready),
        .i_command (i_s_tuser),
        .i_data    (i_s_tdata),
        .o_item    (front_item),
        .o_push    (push)
    );

    wpmc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .i_pop   (pop),
        .o_item  (head_item),
        .o_valid (head_valid),
        .o_full  (q_full)
    );

    wpmc_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg_wr),
        .i_item       (head_item),
        .i_item_valid (head_valid),
        .o_pop        (pop),
        .i_m_tready   (i_m_tready),
        .o_m_tvalid   (o_m_tvalid),
        .o_m_tdata    (o_m_tdata)
    );

endmodule

`default_nettype wire

/* sim/tb_top.sv */
// Self-checking testbench for the waypoint proportional motion controller.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import wpmc_pkg::*;

    localparam int CYCLE_LIMIT  = 800000;
    localparam int DRAIN_CYCLES = 8;

    localparam logic [CMD_W-1:0]     CMD_SPARE    = 2'd3;
    localparam logic [MOTION_W-1:0]  MOTION_KEEP  = 3'd0;
    localparam logic [MOTION_W-1:0]  MOTION_SPARE = 3'd7;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE    = 3'd7;

    localparam int PI_VAL      = PI_Q;
    localparam int TWO_PI_VAL  = TWO_PI_Q;
    localparam int EDGE_ZERO_V = EDGE_ZERO;
    localparam int EDGE_LO_V   = EDGE_NINETY_LO;
    localparam int EDGE_HI_V   = EDGE_NINETY_HI;
    localparam int EDGE_HALF_V = EDGE_HALF;
    localparam int QUARTER_V   = (EDGE_LO_V + EDGE_HI_V) / 2;

    typedef struct packed {
        logic                       reached;
        logic signed [SPEED_W-1:0]  ang;
        logic signed [SPEED_W-1:0]  lin;
    } t_speed_cmd;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_s_tvalid = 1'b0;
    logic                  o_s_tready;
    logic [IN_DATA_W-1:0]  i_s_tdata = '0;
    logic [CMD_W-1:0]      i_s_tuser = '0;
    logic                  o_m_tvalid;
    logic                  i_m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] o_m_tdata;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_addr = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    waypoint_p_motion_controller DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_data  (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    t_speed_cmd speed_cmd_q[$];
    int         mismatch_count = 0;
    int         items_sent = 0;
    int         cycle_count = 0;
    int         rx_hold = 0;
    bit         tx_idle_on = 1'b1;
    bit         rx_stall_on = 1'b1;

    t_mode ctl_mode = MODE_STOP;
    bit    no_cmd_yet = 1'b1;
    bit    robot_at_rest = 1'b0;
    int    rob_x = 0, rob_y = 0, rob_h = 0;
    int    goal_x = 0, goal_y = 0, goal_h = 0;
    int    g_turn = RST_TURN_GAIN;
    int    g_straight = RST_STRAIGHT_GAIN;
    int    lim_lin = RST_LINEAR_LIMIT;
    int    lim_ang = RST_ANGULAR_LIMIT;
    int    tol_dist = RST_DIST_TOL;
    int    tol_head = RST_HEAD_TOL;

    function automatic int sat_negate(int v);
        return (v == int'(COORD_MIN)) ? int'(COORD_MAX) : -v;
    endfunction

    function automatic bit frame_rotate(int h, int x, int y, output int fx, output int fy);
        fx = x;
        fy = y;
        if (h > -EDGE_ZERO_V && h < EDGE_ZERO_V) begin
            return 1'b1;
        end else if (h > EDGE_LO_V && h < EDGE_HI_V) begin
            fx = y;
            fy = sat_negate(x);
            return 1'b1;
        end else if (h > EDGE_HALF_V || h < -EDGE_HALF_V) begin
            fx = sat_negate(x);
            fy = sat_negate(y);
            return 1'b1;
        end else if (h > -EDGE_HI_V && h < -EDGE_LO_V) begin
            fx = sat_negate(y);
            fy = x;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic int gain_clamp(int gain, int err, int limit);
        longint mag, p;
        mag = (err < 0) ? -longint'(err) : longint'(err);
        p = (mag * longint'(gain)) >>> 16;
        if (p > limit) p = limit;
        return (err < 0) ? -int'(p) : int'(p);
    endfunction

    task automatic model_request(input logic [CMD_W-1:0] kind,
                                 input logic signed [COORD_W-1:0] x,
                                 input logic signed [COORD_W-1:0] y,
                                 input logic signed [HEAD_W-1:0] h,
                                 input logic settled, input logic [MOTION_W-1:0] motion);
        int hd, fx, fy, err;
        t_speed_cmd res;
        case (kind)
            CMD_ODOM: begin
                robot_at_rest = settled;
                hd = h;
                if (hd > PI_VAL) hd -= TWO_PI_VAL;
                else if (hd < -PI_VAL) hd += TWO_PI_VAL;
                rob_h = hd;
                if (frame_rotate(hd, x, y, fx, fy)) begin
                    rob_x = fx;
                    rob_y = fy;
                end
            end
            CMD_GOAL: begin
                no_cmd_yet = 1'b0;
                if (frame_rotate(rob_h, x, y, fx, fy)) begin
                    goal_x = fx;
                    goal_y = fy;
                end
                if (motion == MOTION_LEFT || motion == MOTION_RIGHT) begin
                    ctl_mode = MODE_TURN;
                    goal_h = h;
                end else if (motion == MOTION_STRAIGHT) begin
                    ctl_mode = MODE_STRAIGHT;
                end else if (motion == MOTION_STOP) begin
                    ctl_mode = MODE_STOP;
                end
            end
            CMD_TICK: begin
                res.reached = no_cmd_yet || ctl_mode == MODE_STOP;
                res.lin = '0;
                res.ang = '0;
                if (ctl_mode == MODE_TURN) begin
                    if (goal_h == PI_VAL && rob_h < 0) goal_h = -PI_VAL;
                    else if (goal_h == -PI_VAL && rob_h > 0) goal_h = PI_VAL;
                    err = goal_h - rob_h;
                    if (err > PI_VAL) err -= TWO_PI_VAL;
                    else if (err < -PI_VAL) err += TWO_PI_VAL;
                    if (((err < 0) ? -err : err) >= tol_head)
                        res.ang = gain_clamp(g_turn, err, lim_ang);
                    else if (robot_at_rest)
                        ctl_mode = MODE_STOP;
                end else if (ctl_mode == MODE_STRAIGHT) begin
                    err = goal_x - rob_x;
                    if (((err < 0) ? -err : err) >= tol_dist)
                        res.lin = gain_clamp(g_straight, err, lim_lin);
                    else if (robot_at_rest)
                        ctl_mode = MODE_STOP;
                end
                speed_cmd_q.push_back(res);
            end
            default: ;
        endcase
    endtask

    function automatic int idle_length();
        return ($urandom_range(0, 99) < 80) ? $urandom_range(1, 3) : $urandom_range(8, 40);
    endfunction

    function automatic int signed_offset(int span);
        if (span <= 0 || $urandom_range(0, 4) == 0) return 0;
        return int'($urandom_range(0, 2 * span)) - span;
    endfunction

    function automatic int pick_heading();
        logic signed [HEAD_W-1:0] raw;
        int centre;
        raw = $urandom;
        case ($urandom_range(0, 9))
            0, 1: return raw;
            2: begin
                case ($urandom_range(0, 5))
                    0: centre = EDGE_ZERO_V;
                    1: centre = EDGE_LO_V;
                    2: centre = EDGE_HI_V;
                    3: centre = EDGE_HALF_V;
                    4: centre = PI_VAL;
                    default: centre = TWO_PI_VAL;
                endcase
                centre += int'($urandom_range(0, 2)) - 1;
                return $urandom_range(0, 1) ? centre : -centre;
            end
            default: begin
                case ($urandom_range(0, 4))
                    0: centre = 0;
                    1: centre = QUARTER_V;
                    2: centre = -QUARTER_V;
                    3: centre = PI_VAL;
                    default: centre = -PI_VAL;
                endcase
                return centre + signed_offset(11000);
            end
        endcase
    endfunction

    function automatic int pick_coord();
        logic signed [COORD_W-1:0] raw;
        raw = $urandom;
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 3))
                    0: return COORD_MIN;
                    1: return COORD_MAX;
                    2: return 0;
                    default: return -1;
                endcase
            end
            1, 2: return raw;
            default: return signed_offset(1 << 19);
        endcase
    endfunction

    // Receiver: random stalls, most short, a few long.
    always @(posedge i_clk) begin
        if (rx_hold > 0) begin
            rx_hold--;
            i_m_tready <= 1'b0;
        end else if (rx_stall_on && $urandom_range(0, 5) == 0) begin
            rx_hold = idle_length() - 1;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin : check_results
        t_speed_cmd got, want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got = o_m_tdata[2*SPEED_W:0];
            if (speed_cmd_q.size() == 0) begin
                $display("%0t: unexpected result, actual %h", $time, got);
                mismatch_count++;
            end else begin
                want = speed_cmd_q.pop_front();
                if (got.lin !== want.lin) begin
                    $display("%0t: linear_speed expected %0d actual %0d",
                             $time, want.lin, got.lin);
                    mismatch_count++;
                end
                if (got.ang !== want.ang) begin
                    $display("%0t: angular_speed expected %0d actual %0d",
                             $time, want.ang, got.ang);
                    mismatch_count++;
                end
                if (got.reached !== want.reached) begin
                    $display("%0t: reached expected %0d actual %0d",
                             $time, want.reached, got.reached);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results outstanding", $time, speed_cmd_q.size());
            $display("tb: failure");
            $finish;
        end
    end

    task automatic send_request(input logic [CMD_W-1:0] kind,
                                input logic signed [COORD_W-1:0] x,
                                input logic signed [COORD_W-1:0] y,
                                input logic signed [HEAD_W-1:0] h,
                                input logic settled, input logic [MOTION_W-1:0] motion);
        int gap;
        gap = (tx_idle_on && $urandom_range(0, 1)) ? idle_length() : 0;
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= kind;
        i_s_tdata  <= {motion, settled, h, y, x};
        do @(posedge i_clk); while (!o_s_tready);
        model_request(kind, x, y, h, settled, motion);
        if (kind != CMD_SPARE) items_sent++;
    endtask

    task automatic send_odometry(input int x, input int y, input int h, input logic settled);
        send_request(CMD_ODOM, x, y, h, settled, 3'($urandom));
    endtask

    task automatic send_goal(input int x, input int y, input int h,
                             input logic [MOTION_W-1:0] motion);
        send_request(CMD_GOAL, x, y, h, 1'($urandom), motion);
    endtask

    task automatic send_tick();
        send_request(CMD_TICK, $urandom, $urandom, $urandom, 1'($urandom), 3'($urandom));
    endtask

    task automatic wait_drain();
        i_s_tvalid <= 1'b0;
        while (speed_cmd_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Leaves the write valid high; the caller lowers it after the last write.
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_TURN_GAIN:     g_turn = value;
            CFG_STRAIGHT_GAIN: g_straight = value;
            CFG_LINEAR_LIMIT:  lim_lin = value[LIMIT_W-1:0];
            CFG_ANGULAR_LIMIT: lim_ang = value[LIMIT_W-1:0];
            CFG_DIST_TOL:      tol_dist = value[TOL_W-1:0];
            CFG_HEAD_TOL:      tol_head = value[TOL_W-1:0];
            default: ;
        endcase
    endtask

    task automatic apply_settings(input int tg, input int sg, input int ll, input int al,
                                  input int dt, input int ht, input bit touch_spare);
        wait_drain();
        if (touch_spare) write_register(CFG_SPARE, $urandom);
        write_register(CFG_TURN_GAIN, tg);
        write_register(CFG_STRAIGHT_GAIN, sg);
        write_register(CFG_LINEAR_LIMIT, ll);
        write_register(CFG_ANGULAR_LIMIT, al);
        write_register(CFG_DIST_TOL, dt);
        write_register(CFG_HEAD_TOL, ht);
        i_cfg_valid <= 1'b0;
    endtask

    // Odometry, a goal, then ticks with odometry closing in on the goal.
    task automatic run_episode();
        int h0, x0, y0, gx, gy, gh, span, hspan, steps, i;
        logic [MOTION_W-1:0] motion;
        h0 = pick_heading();
        x0 = pick_coord();
        y0 = pick_coord();
        send_odometry(x0, y0, h0, 1'b0);
        case ($urandom_range(0, 9))
            0, 1, 2, 3: motion = $urandom_range(0, 1) ? MOTION_LEFT : MOTION_RIGHT;
            4, 5, 6, 7: motion = MOTION_STRAIGHT;
            8:          motion = MOTION_STOP;
            default:    motion = $urandom_range(0, 1) ? MOTION_KEEP : MOTION_SPARE - 3'($urandom_range(0, 2));
        endcase
        gx = x0 + signed_offset(1 << 18);
        gy = y0 + signed_offset(1 << 16);
        case ($urandom_range(0, 7))
            0:       gh = PI_VAL;
            1:       gh = -PI_VAL;
            2:       gh = pick_heading();
            default: gh = h0 + signed_offset(60000);
        endcase
        send_goal(gx, gy, gh, motion);
        span = 1 << 17;
        hspan = 1 << 15;
        steps = $urandom_range(2, 14);
        for (i = 0; i < steps; i++) begin
            if ($urandom_range(0, 9) < 7) begin
                if (motion == MOTION_STRAIGHT)
                    send_odometry(gx + signed_offset(span), gy + signed_offset(span), h0,
                                  $urandom_range(0, 9) < 6);
                else
                    send_odometry(x0, y0, gh + signed_offset(hspan), $urandom_range(0, 9) < 6);
            end
            send_tick();
            span = span >>> 1;
            hspan = hspan >>> 1;
        end
    endtask

    task automatic run_random_traffic(input int n);
        int stop_at, pause_at;
        bit paused;
        stop_at = items_sent + n;
        pause_at = items_sent + n / 2;
        paused = 1'b0;
        while (items_sent < stop_at) begin
            if (!paused && items_sent >= pause_at) begin
                wait_drain();
                paused = 1'b1;
            end
            if ($urandom_range(0, 99) < 15)
                send_request(2'($urandom), pick_coord(), pick_coord(), pick_heading(),
                             1'($urandom), 3'($urandom));
            else
                run_episode();
        end
    endtask

    task automatic test_reset_state();
        send_tick();
        send_request(CMD_SPARE, $urandom, $urandom, $urandom, 1'($urandom), 3'($urandom));
        send_tick();
    endtask

    task automatic test_directed_cases();
        send_odometry(COORD_MAX, COORD_MIN, -524288, 1'b0);
        send_odometry(COORD_MIN, 77, 524287, 1'b0);
        send_odometry(COORD_MIN, COORD_MIN, PI_VAL, 1'b0);
        send_odometry(1234, -5678, -PI_VAL, 1'b1);
        send_odometry(12345, -5, EDGE_ZERO_V, 1'b0);
        send_odometry(1 << 16, 0, 0, 1'b1);
        send_goal(3 << 16, 1 << 16, 0, MOTION_KEEP);
        send_tick();
        send_goal(5 << 16, 0, 0, MOTION_STRAIGHT);
        send_tick();
        send_goal(5 << 16, 0, 0, MOTION_SPARE);
        send_odometry((5 << 16) - 100, 0, 0, 1'b1);
        send_tick();
        send_tick();
        send_odometry(0, 0, -1000, 1'b0);
        send_goal(0, 0, PI_VAL, MOTION_LEFT);
        send_tick();
        send_odometry(0, 0, 1000, 1'b1);
        send_goal(0, 0, -PI_VAL, MOTION_RIGHT);
        send_tick();
        send_goal(0, 0, -524288, MOTION_LEFT);
        send_tick();
        send_goal(0, 0, 0, MOTION_STOP);
        send_tick();
    endtask

    task automatic test_register_sweep();
        int phase;
        for (phase = 0; phase < 8; phase++) begin
            case (phase)
                0: ;
                1: apply_settings(0, 0, 0, 0, 0, 0, 1'b0);
                2: apply_settings(1048576, 1048576, 262144, 262144, 65536, 65536, 1'b0);
                3: apply_settings(21'h1FFFFF, 21'h1FFFFF, 21'h1FFFFF, 21'h1FFFFF,
                                  21'h1FFFFF, 21'h1FFFFF, 1'b0);
                4, 5: apply_settings($urandom_range(0, 1048576), $urandom_range(0, 1048576),
                                     $urandom_range(0, 262144), $urandom_range(0, 262144),
                                     $urandom_range(0, 65536), $urandom_range(0, 65536), 1'b0);
                6: apply_settings($urandom, $urandom, $urandom, $urandom,
                                  $urandom, $urandom, 1'b0);
                default: apply_settings(RST_TURN_GAIN, RST_STRAIGHT_GAIN, RST_LINEAR_LIMIT,
                                        RST_ANGULAR_LIMIT, RST_DIST_TOL, RST_HEAD_TOL, 1'b1);
            endcase
            run_random_traffic(200);
        end
    endtask

    task automatic test_back_to_back();
        tx_idle_on = 1'b0;
        rx_stall_on = 1'b0;
        run_random_traffic(120);
        tx_idle_on = 1'b1;
        rx_stall_on = 1'b1;
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_state();
        test_directed_cases();
        test_register_sweep();
        test_back_to_back();
        wait_drain();
        if (mismatch_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

/* filelist.f */
hw/rtl/wpmc_pkg.sv
hw/rtl/wpmc_front.sv
hw/rtl/wpmc_queue.sv
hw/rtl/wpmc_back.sv
hw/rtl/waypoint_p_motion_controller.sv
sim/tb_top.sv
